// File: rtl/bitmap_first_free_allocator_unit_macros.svh
// Assertion macros for the bitmap allocator
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BFFA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFFA_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BFFA_ASSERT_IMP(name, ante, cons, msg)
`define BFFA_ASSERT_NXT(name, ante, cons, msg)

`endif

`endif

// File: rtl/bffa_pkg.sv
package bffa_pkg;

    // bitmap geometry
    localparam int WORDS     = 32;
    localparam int WORD_BITS = 32;
    localparam int WORD_AW   = $clog2(WORDS);
    localparam int BIT_AW    = $clog2(WORD_BITS);

    // field widths
    localparam int OP_W  = 3;
    localparam int IDX_W = 10;
    localparam int CNT_W = 6;
    localparam int RES_W = WORD_AW + BIT_AW;

    localparam logic [CNT_W-1:0] WORDS_IN_USE_RST = CNT_W'(32);

    // opcodes
    localparam logic [OP_W-1:0] OP_SET     = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd1;
    localparam logic [OP_W-1:0] OP_TEST    = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND    = 3'd3;
    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd4;
    localparam logic [OP_W-1:0] OP_CLR_ALL = 3'd5;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RMW  = 3'b010,
        S_SCAN = 3'b100
    } state_t;

    // position of the lowest zero bit of a word
    function automatic logic [BIT_AW-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] inv;
        logic [WORD_BITS-1:0] iso;
        logic [BIT_AW-1:0]    pos;
        inv = ~w;
        iso = inv & (~inv + WORD_BITS'(1));
        pos = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (iso[b])
            begin
                pos = pos | BIT_AW'(b);
            end
        end
        return pos;
    endfunction

endpackage

// File: rtl/bitmap_first_free_allocator_unit.sv
// Channel   Handshake            Payload
// -------   ------------------   -----------------------------------
// command   start / busy         opcode, bit_index
// result    done (1-cycle pulse) found, result_index, index_error
// config    cfg_we               cfg_wdata (words_in_use)
//
// Set, clear, test in range: memory read, then write back (set, clear) or bit test (test).
// Find, allocate: words scanned in order from word 0 (at most words_in_use, capped at 32),
//   one word per cycle through the single memory read port.
// Clear all, out-of-range index, unused opcode: result next cycle, busy stays low.
// Reset clears 32 per-word valid flags at once; clear all drops the flags of the words in use at once.
// The result pulse cannot be held off; start is taken whenever busy is low.
`include "bitmap_first_free_allocator_unit_macros.svh"

module bitmap_first_free_allocator_unit
    import bffa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   opcode,
    input  logic [IDX_W-1:0]  bit_index,
    output logic              done,
    output logic              found,
    output logic [IDX_W-1:0]  result_index,
    output logic              index_error,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_wdata
);

    // control and payload registers
    state_t               state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [WORD_AW-1:0]   word_reg, word_next;
    logic [BIT_AW-1:0]    off_reg, off_next;
    logic [WORD_AW-1:0]   scan_w_reg, scan_w_next;
    logic [WORDS-1:0]     valid_reg, valid_next;
    logic [CNT_W-1:0]     words_in_use_reg;
    logic                 done_reg, done_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     result_index_reg, result_index_next;
    logic                 index_error_reg, index_error_next;

    // memory and its ports
    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_valid_reg;
    logic                 rd_en;
    logic [WORD_AW-1:0]   rd_addr;
    logic                 wr_en;
    logic [WORD_AW-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // decode helpers
    logic                 accept;
    logic [CNT_W-1:0]     n_words;
    logic [IDX_W-1:0]     in_word;
    logic                 in_range;
    logic [WORD_BITS-1:0] cur_word;
    logic [WORD_BITS-1:0] bit_mask;
    logic [BIT_AW-1:0]    free_pos;
    logic [RES_W-1:0]     free_full;
    logic                 last_word;

    assign accept   = start && !busy;
    assign n_words  = (words_in_use_reg > CNT_W'(WORDS)) ? CNT_W'(WORDS) : words_in_use_reg;
    assign in_word  = bit_index >> BIT_AW;
    assign in_range = in_word < IDX_W'(n_words);

    // word read last cycle; unwritten words read as zero
    assign cur_word  = rd_valid_reg ? rd_data_reg : '0;
    assign bit_mask  = WORD_BITS'(1) << off_reg;
    assign free_pos  = lowest_zero(cur_word);
    assign free_full = {scan_w_reg, free_pos};
    assign last_word = (CNT_W'(scan_w_reg) + CNT_W'(1)) >= n_words;

    // next-state logic
    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        word_next         = word_reg;
        off_next          = off_reg;
        scan_w_next       = scan_w_reg;
        valid_next        = valid_reg;
        done_next         = 1'b0;
        found_next        = found_reg;
        result_index_next = result_index_reg;
        index_error_next  = index_error_reg;
        rd_en             = 1'b0;
        rd_addr           = '0;
        wr_en             = 1'b0;
        wr_addr           = word_reg;
        wr_data           = cur_word;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next           = opcode;
                    word_next         = WORD_AW'(in_word);
                    off_next          = bit_index[BIT_AW-1:0];
                    found_next        = 1'b0;
                    result_index_next = '0;
                    index_error_next  = 1'b0;
                    if (opcode == OP_SET || opcode == OP_CLEAR || opcode == OP_TEST)
                    begin
                        if (in_range)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = WORD_AW'(in_word);
                            state_next = S_RMW;
                        end
                        else
                        begin
                            index_error_next = 1'b1;
                            done_next        = 1'b1;
                        end
                    end
                    else if (opcode == OP_FIND || opcode == OP_ALLOC)
                    begin
                        if (n_words != '0)
                        begin
                            rd_en       = 1'b1;
                            rd_addr     = '0;
                            scan_w_next = '0;
                            state_next  = S_SCAN;
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                    end
                    else if (opcode == OP_CLR_ALL)
                    begin
                        for (int i = 0; i < WORDS; i++)
                        begin
                            if (CNT_W'(i) < n_words)
                            begin
                                valid_next[i] = 1'b0;
                            end
                        end
                        done_next = 1'b1;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end

            S_RMW:
            begin
                wr_addr = word_reg;
                if (op_reg == OP_SET)
                begin
                    wr_en   = 1'b1;
                    wr_data = cur_word | bit_mask;
                end
                else if (op_reg == OP_CLEAR)
                begin
                    wr_en   = 1'b1;
                    wr_data = cur_word & ~bit_mask;
                end
                else
                begin
                    found_next = |(cur_word & bit_mask);
                end
                if (wr_en)
                begin
                    valid_next[word_reg] = 1'b1;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_SCAN:
            begin
                // keep the read port busy with the next word
                rd_en   = 1'b1;
                rd_addr = scan_w_reg + WORD_AW'(1);
                if (!(&cur_word))
                begin
                    found_next        = 1'b1;
                    result_index_next = IDX_W'(free_full);
                    if (op_reg == OP_ALLOC)
                    begin
                        wr_en                  = 1'b1;
                        wr_addr                = scan_w_reg;
                        wr_data                = cur_word | (WORD_BITS'(1) << free_pos);
                        valid_next[scan_w_reg] = 1'b1;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (last_word)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_w_next = scan_w_reg + WORD_AW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // bitmap memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            valid_reg        <= '0;
            words_in_use_reg <= WORDS_IN_USE_RST;
            done_reg         <= 1'b0;
            found_reg        <= 1'b0;
            result_index_reg <= '0;
            index_error_reg  <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            valid_reg        <= valid_next;
            done_reg         <= done_next;
            found_reg        <= found_next;
            result_index_reg <= result_index_next;
            index_error_reg  <= index_error_next;
            if (cfg_we)
            begin
                words_in_use_reg <= cfg_wdata;
            end
        end
    end

    // item context
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        word_reg   <= word_next;
        off_reg    <= off_next;
        scan_w_reg <= scan_w_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign found        = found_reg;
    assign result_index = result_index_reg;
    assign index_error  = index_error_reg;

    // checks
    `BFFA_ASSERT_NXT(a_rmw_one_cycle, state_reg == S_RMW, done_reg && !busy, "rmw did not finish")
    `BFFA_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(state_reg), "state not one-hot")
    `BFFA_ASSERT_IMP(a_err_not_found, done_reg && index_error_reg, !found_reg, "error with found")
    `BFFA_ASSERT_NXT(a_alloc_write_ends, state_reg == S_SCAN && wr_en, !busy, "scan kept going")
    `BFFA_ASSERT_NXT(a_clr_all_fast, accept && opcode == OP_CLR_ALL, done_reg && !busy, "clear all slow")

endmodule
